// ===== sv/sha1_message_digest_top_macros.svh =====
// Assertion macros shared by the SHA-1 RTL.
`ifndef SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sha1_pkg.sv =====
package sha1_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam int BLOCK_WORDS = 16;
    localparam int LEN_WORD    = 14;
    localparam int ROUNDS      = 80;
    localparam int DIGEST_WORDS = 5;

    localparam int WCNT_W  = $clog2(BLOCK_WORDS + 1);
    localparam int RND_W   = $clog2(ROUNDS);
    localparam int OIDX_W  = $clog2(DIGEST_WORDS);
    localparam int BCNT_W  = 61;

    localparam t_word K0 = 32'h5a827999;
    localparam t_word K1 = 32'h6ed9eba1;
    localparam t_word K2 = 32'h8f1bbcdc;
    localparam t_word K3 = 32'hca62c1d6;

    localparam t_word IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== sv/sha1_round.sv =====
module sha1_round
    import sha1_pkg::*;
(
    input  t_vars            i_vars,
    input  t_word            i_w,
    input  logic [RND_W-1:0] i_rnd,
    output t_vars            o_vars
);

    t_word f;
    t_word k;
    t_word t;

    always_comb begin
        if (i_rnd < RND_W'(20)) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K0;
        end else if (i_rnd < RND_W'(40)) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K1;
        end else if (i_rnd < RND_W'(60)) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K3;
        end
        t = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + i_w + k;
        o_vars.a = t;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

// ===== sv/sha1_message_digest_top.sv =====
// SHA-1 message digest, one message byte per input transaction.
// Input channel s_axis: tuser = 0 carries a message byte in tdata, tuser = 1
// finishes the message (tdata ignored). Output channel m_axis: five digest
// words H0..H4, tlast on H4.
// The byte that completes a 64-byte block holds s_axis_tready low through 80
// rounds through one shared round unit, then the chain update. A finish
// transaction pads the block by word shifts, runs one or two compressions,
// then offers the digest: first word in the cycle after the last chain update,
// one word per cycle while m_axis_tready is high. A stall on m_axis holds the
// current word; no input is taken until all five words have gone out.
// After the fifth word the chain value, length and fill position are back
// at their initial values, ready for the next message.
// Reset (i_rst_n low, synchronous) drops any partial message and digest and
// returns the block to idle with the SHA-1 initial chain value.
module sha1_message_digest_top
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast
);

    `include "sha1_message_digest_top_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_LEN_HI, S_LEN_LO, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state              r_state;
    t_word               r_h [DIGEST_WORDS];
    t_word               r_w [BLOCK_WORDS];
    t_word               r_acc;
    logic [1:0]          r_lane;
    logic [WCNT_W-1:0]   r_wcnt;
    logic [BCNT_W-1:0]   r_bytes;
    logic [RND_W-1:0]    r_rnd;
    logic [OIDX_W-1:0]   r_oidx;
    logic                r_fin;
    logic                r_long;
    logic                r_more;
    t_vars               r_v;

    t_vars               n_v;
    t_vars               init_v;
    t_word               byte_word;
    t_word               pad_word;
    t_word               sched_word;
    t_word               sched_word_rot;
    logic [63:0]         bit_len;
    logic                fill_done;
    logic                in_fire;
    logic                out_fire;

    sha1_round u_round (
        .i_vars (r_v),
        .i_w    (r_w[0]),
        .i_rnd  (r_rnd),
        .o_vars (n_v)
    );

    assign init_v     = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
    assign byte_word  = ((r_lane == 2'd0) ? '0 : r_acc)
                        | (32'(s_axis_tdata) << {~r_lane, 3'b000});
    assign pad_word   = ((r_lane == 2'd0) ? '0 : r_acc)
                        | (32'(PAD_BYTE) << {~r_lane, 3'b000});
    assign sched_word = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign sched_word_rot = {sched_word[30:0], sched_word[31]};
    assign bit_len    = {r_bytes, 3'b000};
    assign fill_done  = r_long ? (r_wcnt == WCNT_W'(BLOCK_WORDS))
                               : (r_wcnt == WCNT_W'(LEN_WORD));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_h[0];
    assign m_axis_tlast  = (r_oidx == OIDX_W'(DIGEST_WORDS - 1));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= IV;
            r_lane  <= '0;
            r_wcnt  <= '0;
            r_bytes <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_fin   <= 1'b0;
            r_long  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && !s_axis_tuser) begin
                        r_bytes <= r_bytes + BCNT_W'(1);
                        r_lane  <= r_lane + 2'd1;
                        r_acc   <= byte_word;
                        if (r_lane == 2'd3) begin
                            for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                            r_w[BLOCK_WORDS-1] <= byte_word;
                            r_wcnt <= r_wcnt + WCNT_W'(1);
                            if (r_wcnt == WCNT_W'(BLOCK_WORDS - 1)) begin
                                r_v     <= init_v;
                                r_rnd   <= '0;
                                r_state <= S_ROUND;
                            end
                        end
                    end else if (in_fire) begin
                        for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                        r_w[BLOCK_WORDS-1] <= pad_word;
                        r_wcnt  <= r_wcnt + WCNT_W'(1);
                        r_lane  <= '0;
                        r_fin   <= 1'b1;
                        r_long  <= (r_wcnt >= WCNT_W'(LEN_WORD));
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (!fill_done) begin
                        for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                        r_w[BLOCK_WORDS-1] <= '0;
                        r_wcnt <= r_wcnt + WCNT_W'(1);
                    end else if (r_long) begin
                        r_long  <= 1'b0;
                        r_more  <= 1'b1;
                        r_v     <= init_v;
                        r_rnd   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_state <= S_LEN_HI;
                    end
                end
                S_LEN_HI: begin
                    for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                    r_w[BLOCK_WORDS-1] <= bit_len[63:32];
                    r_state <= S_LEN_LO;
                end
                S_LEN_LO: begin
                    for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                    r_w[BLOCK_WORDS-1] <= bit_len[31:0];
                    r_v     <= init_v;
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int j = 0; j < BLOCK_WORDS - 1; j++) r_w[j] <= r_w[j+1];
                    r_w[BLOCK_WORDS-1] <= sched_word_rot;
                    r_v   <= n_v;
                    r_rnd <= r_rnd + RND_W'(1);
                    if (r_rnd == RND_W'(ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_v.a;
                    r_h[1] <= r_h[1] + r_v.b;
                    r_h[2] <= r_h[2] + r_v.c;
                    r_h[3] <= r_h[3] + r_v.d;
                    r_h[4] <= r_h[4] + r_v.e;
                    r_wcnt <= '0;
                    if (r_more) begin
                        r_more  <= 1'b0;
                        r_state <= S_FILL;
                    end else if (r_fin) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        if (m_axis_tlast) begin
                            r_h     <= IV;
                            r_bytes <= '0;
                            r_wcnt  <= '0;
                            r_lane  <= '0;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            for (int j = 0; j < DIGEST_WORDS - 1; j++) r_h[j] <= r_h[j+1];
                            r_oidx <= r_oidx + OIDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SHA1_ASSERT_NOW(a_no_overlap, 1'b1, !(s_axis_tready && m_axis_tvalid),
        "input taken while digest pending")
    `SHA1_ASSERT_NOW(a_wcnt_range, 1'b1, r_wcnt <= WCNT_W'(BLOCK_WORDS),
        "word count past block size")
    `SHA1_ASSERT_NEXT(a_round_exit, (r_state == S_ROUND) && (r_rnd == RND_W'(ROUNDS - 1)),
        r_state == S_ADD, "compression did not end after last round")
    `SHA1_ASSERT_NEXT(a_restart, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready && (r_bytes == '0) && (r_h[0] == IV[0]),
        "state not restored after digest")

endmodule
